### design/salct_pkg.sv
// shared types, constants and helpers for the set-associative lru cache tag store
package salct_pkg;

	localparam int MAX_SETS  = 256;
	localparam int MAX_WAYS  = 8;
	localparam int ADDR_BITS = 32;

	localparam int SET_W   = $clog2(MAX_SETS);
	localparam int WAY_W   = $clog2(MAX_WAYS);
	localparam int TAG_W   = ADDR_BITS;
	localparam int CFG_W   = 4;
	localparam int SHIFT_W = 5;

	// configuration register indexes (paddr[3:2])
	localparam logic [1:0] REG_SET_INDEX_BITS = 2'd0;
	localparam logic [1:0] REG_WAYS_USED      = 2'd1;
	localparam logic [1:0] REG_OFFSET_BITS    = 2'd2;

	localparam logic [CFG_W-1:0] SET_INDEX_BITS_RST = 4'd4;
	localparam logic [CFG_W-1:0] WAYS_USED_RST      = 4'd8;
	localparam logic [CFG_W-1:0] OFFSET_BITS_RST    = 4'd3;

	// access kinds
	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// result codes
	localparam logic [1:0] OUT_MISS    = 2'd0;
	localparam logic [1:0] OUT_HIT     = 2'd1;
	localparam logic [1:0] OUT_MISS_WB = 2'd2;

	typedef struct packed {
		logic             valid;
		logic             dirty;
		logic [TAG_W-1:0] tag;
		logic [WAY_W-1:0] rank;
	} line_t;

	typedef line_t [MAX_WAYS-1:0] row_t;

	// contents of a set right after reset
	function automatic row_t init_row();
		row_t r;
		for (int w = 0; w < MAX_WAYS; w++) begin
			r[w].valid = 1'b0;
			r[w].dirty = 1'b0;
			r[w].tag   = '0;
			r[w].rank  = WAY_W'(w);
		end
		return r;
	endfunction

endpackage

### design/set_assoc_lru_cache_tags.sv
// set-associative write-back lru cache tag store: address split, lookup and replacement
//
// Usage: raise start with cmd (0 read, 1 write) and addr for one cycle while busy is low;
// the access is taken at that clock edge. busy is then high for one cycle while the
// set row read out of the tag memory is checked and the updated row is written back.
// At the edge that ends that cycle done pulses high for one cycle with outcome
// (0 miss, 1 hit, 2 miss with dirty victim writeback); the receiver must take it then.
// The tag memory is read at the edge that takes the access and the updated row is
// written at the edge that ends the busy cycle; a new access is not taken while busy
// is high, so it waits for that write and no forwarding is needed.
// Each set is one memory row holding all ways (valid, dirty, tag, recency rank).
// After reset every row is flagged unwritten and reads as the reset contents
// (all invalid, rank equal to way number), so no clearing pass is needed.
// Configuration goes through the apb port at byte addresses 0 (set_index_bits),
// 4 (ways_used) and 8 (offset_bits); it should only be written while busy is low.
// An asynchronous reset drops any access in flight and restores register defaults.
module set_assoc_lru_cache_tags
	import salct_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 cmd,
	input  logic [ADDR_BITS-1:0] addr,
	output logic                 done,
	output logic [1:0]           outcome,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	logic [CFG_W-1:0] set_bits_q, ways_q, off_bits_q;
	logic             busy_q, done_q;
	logic [1:0]       outcome_q;
	logic [MAX_SETS-1:0] row_init_q;

	logic             cmd_s1;
	logic [SET_W-1:0] set_s1;
	logic [TAG_W-1:0] tag_s1;
	logic             row_live_s1;
	row_t             rdata_s1;

	row_t tag_mem [MAX_SETS];

	logic                 accept;
	logic                 cfg_wr;
	logic [CFG_W-1:0]     set_bits_eff, ways_eff;
	logic [SHIFT_W-1:0]   tag_shift;
	logic [SET_W-1:0]     set_mask, addr_set;
	logic [ADDR_BITS-1:0] addr_shifted;
	logic [TAG_W-1:0]     addr_tag;

	row_t             row_cur, row_nxt;
	logic             hit_any, free_any;
	logic [WAY_W-1:0] hit_way, free_way, lru_way, touch_way, worst, old_rank;
	logic [1:0]       outcome_nxt;

	assign accept = start && !busy_q;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign busy   = busy_q;
	assign done   = done_q;
	assign outcome = outcome_q;

	// register read back
	always_comb begin
		prdata = '0;
		case (paddr[3:2])
			REG_SET_INDEX_BITS: prdata = 32'(set_bits_q);
			REG_WAYS_USED:      prdata = 32'(ways_q);
			REG_OFFSET_BITS:    prdata = 32'(off_bits_q);
			default:            prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q <= SET_INDEX_BITS_RST;
			ways_q     <= WAYS_USED_RST;
			off_bits_q <= OFFSET_BITS_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_SET_INDEX_BITS: set_bits_q <= pwdata[CFG_W-1:0];
				REG_WAYS_USED:      ways_q     <= pwdata[CFG_W-1:0];
				REG_OFFSET_BITS:    off_bits_q <= pwdata[CFG_W-1:0];
				default:            ;
			endcase
		end
	end

	// clamp set_index_bits and ways_used to what the store can hold
	always_comb begin
		set_bits_eff = (set_bits_q > CFG_W'(SET_W)) ? CFG_W'(SET_W) : set_bits_q;
		if (ways_q == '0)
			ways_eff = CFG_W'(1);
		else if (ways_q > CFG_W'(MAX_WAYS))
			ways_eff = CFG_W'(MAX_WAYS);
		else
			ways_eff = ways_q;
	end

	// address split
	always_comb begin
		tag_shift    = SHIFT_W'(off_bits_q) + SHIFT_W'(set_bits_eff);
		set_mask     = SET_W'((($bits(set_mask) + 1)'(1) << set_bits_eff) - 1'b1);
		addr_shifted = addr >> off_bits_q;
		addr_set     = addr_shifted[SET_W-1:0] & set_mask;
		addr_tag     = TAG_W'(addr >> tag_shift);
	end

	// tag memory: read on accept, write back the updated row at the end of the busy cycle
	always_ff @(posedge clk) begin
		if (busy_q)
			tag_mem[set_s1] <= row_nxt;
		if (accept)
			rdata_s1 <= tag_mem[addr_set];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1      <= cmd;
			set_s1      <= addr_set;
			tag_s1      <= addr_tag;
			row_live_s1 <= row_init_q[addr_set];
		end
		if (busy_q)
			outcome_q <= outcome_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			done_q     <= 1'b0;
			row_init_q <= '0;
		end else begin
			busy_q <= accept;
			done_q <= busy_q;
			if (busy_q)
				row_init_q[set_s1] <= 1'b1;
		end
	end

	// lookup, victim choice and recency update on the row read out
	always_comb begin
		row_cur  = row_live_s1 ? rdata_s1 : init_row();
		hit_any  = 1'b0;
		hit_way  = '0;
		free_any = 1'b0;
		free_way = '0;
		lru_way  = '0;
		worst    = '0;
		// scan downward so the lowest-numbered way wins
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (CFG_W'(w) < ways_eff) begin
				if (row_cur[w].valid && row_cur[w].tag == tag_s1) begin
					hit_any = 1'b1;
					hit_way = WAY_W'(w);
				end
				if (!row_cur[w].valid) begin
					free_any = 1'b1;
					free_way = WAY_W'(w);
				end
			end
		end
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (CFG_W'(w) < ways_eff && row_cur[w].rank >= worst) begin
				worst   = row_cur[w].rank;
				lru_way = WAY_W'(w);
			end
		end
		if (hit_any)
			touch_way = hit_way;
		else if (free_any)
			touch_way = free_way;
		else
			touch_way = lru_way;

		old_rank = row_cur[touch_way].rank;
		row_nxt  = row_cur;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (row_cur[w].rank < old_rank)
				row_nxt[w].rank = row_cur[w].rank + 1'b1;
		end
		row_nxt[touch_way].rank = '0;

		if (hit_any) begin
			outcome_nxt = OUT_HIT;
			if (cmd_s1 == CMD_WRITE)
				row_nxt[touch_way].dirty = 1'b1;
		end else begin
			outcome_nxt = (row_cur[touch_way].valid && row_cur[touch_way].dirty) ?
				OUT_MISS_WB : OUT_MISS;
			row_nxt[touch_way].valid = 1'b1;
			row_nxt[touch_way].tag   = tag_s1;
			row_nxt[touch_way].dirty = (cmd_s1 == CMD_WRITE);
		end
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q)
		else $error("accepted transaction did not start the lookup");

	a_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> (!busy_q && done_q))
		else $error("lookup did not finish in one cycle");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("result without a lookup");

	a_outcome_code: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (outcome_q == OUT_MISS || outcome_q == OUT_HIT || outcome_q == OUT_MISS_WB))
		else $error("bad outcome code");

	a_row_marked: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> row_init_q[$past(set_s1)])
		else $error("written set not marked live");

endmodule
